// ===== hw/rtl/utf8_stream_validator_unit_macros.svh =====
// Assertion macros shared by the validator RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef UTF8_STREAM_VALIDATOR_UNIT_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define U8V_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8v assertion failed");
// Next-cycle implication
`define U8V_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8v assertion failed");
`else
`define U8V_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define U8V_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/u8v_pkg.sv =====
// Shared types and constants of the UTF-8 stream validator.
// Used by the byte lanes, the merge stage and the top level.
package u8v_pkg;

  // Bytes carried by one input item; one decode lane per byte
  localparam int BYTES_PER_ITEM = 8;

  // Range class of the next continuation byte
  typedef logic [2:0] cont_class_t;
  localparam cont_class_t CLS_NORMAL = 3'd0;  // 80..BF
  localparam cont_class_t CLS_E0     = 3'd1;  // A0..BF
  localparam cont_class_t CLS_ED     = 3'd2;  // 80..9F
  localparam cont_class_t CLS_F0     = 3'd3;  // 90..BF
  localparam cont_class_t CLS_F4     = 3'd4;  // 80..8F

  // Byte bounds
  localparam logic [7:0] ASCII_MAX   = 8'h7F;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [7:0] LEAD3_E0    = 8'hE0;
  localparam logic [7:0] LEAD3_ED    = 8'hED;
  localparam logic [7:0] LEAD3_MAX   = 8'hEF;
  localparam logic [7:0] LEAD4_F0    = 8'hF0;
  localparam logic [7:0] LEAD4_F4    = 8'hF4;
  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hBF;
  localparam logic [7:0] CONT_E0_MIN = 8'hA0;
  localparam logic [7:0] CONT_ED_MAX = 8'h9F;
  localparam logic [7:0] CONT_F0_MIN = 8'h90;
  localparam logic [7:0] CONT_F4_MAX = 8'h8F;

  // What one lane finds about its byte
  typedef struct packed {
    logic        lead_ok;    // byte may start a sequence (ASCII included)
    logic [1:0]  lead_owed;  // continuations the lead asks for
    cont_class_t lead_cls;   // range of its first continuation
    logic        in_normal;
    logic        in_e0;
    logic        in_ed;
    logic        in_f0;
    logic        in_f4;
  } lane_info_t;

  // Verdict handed from the merge stage to the output buffer
  typedef struct packed {
    logic valid;
    logic ok;
  } verdict_t;

endpackage

// ===== hw/rtl/u8v_lane.sv =====
// One byte decode lane: lead class and continuation range checks.
// Depends on u8v_pkg.
module u8v_lane (
  input  logic [7:0]          byte_in,
  output u8v_pkg::lane_info_t info
);

  // Classify the byte as a lead
  always_comb begin
    info.lead_ok   = 1'b1;
    info.lead_owed = 2'd0;
    info.lead_cls  = u8v_pkg::CLS_NORMAL;
    if (byte_in <= u8v_pkg::ASCII_MAX) begin
      info.lead_ok = 1'b1;
    end else if (byte_in >= u8v_pkg::LEAD2_MIN && byte_in <= u8v_pkg::LEAD2_MAX) begin
      info.lead_owed = 2'd1;
    end else if (byte_in == u8v_pkg::LEAD3_E0) begin
      info.lead_owed = 2'd2;
      info.lead_cls  = u8v_pkg::CLS_E0;
    end else if (byte_in == u8v_pkg::LEAD3_ED) begin
      info.lead_owed = 2'd2;
      info.lead_cls  = u8v_pkg::CLS_ED;
    end else if (byte_in > u8v_pkg::LEAD3_E0 && byte_in <= u8v_pkg::LEAD3_MAX) begin
      info.lead_owed = 2'd2;
    end else if (byte_in == u8v_pkg::LEAD4_F0) begin
      info.lead_owed = 2'd3;
      info.lead_cls  = u8v_pkg::CLS_F0;
    end else if (byte_in == u8v_pkg::LEAD4_F4) begin
      info.lead_owed = 2'd3;
      info.lead_cls  = u8v_pkg::CLS_F4;
    end else if (byte_in > u8v_pkg::LEAD4_F0 && byte_in < u8v_pkg::LEAD4_F4) begin
      info.lead_owed = 2'd3;
    end else begin
      info.lead_ok = 1'b0;
    end

    // Check the byte against each continuation range
    info.in_normal = byte_in >= u8v_pkg::CONT_MIN && byte_in <= u8v_pkg::CONT_MAX;
    info.in_e0     = byte_in >= u8v_pkg::CONT_E0_MIN && byte_in <= u8v_pkg::CONT_MAX;
    info.in_ed     = byte_in >= u8v_pkg::CONT_MIN && byte_in <= u8v_pkg::CONT_ED_MAX;
    info.in_f0     = byte_in >= u8v_pkg::CONT_F0_MIN && byte_in <= u8v_pkg::CONT_MAX;
    info.in_f4     = byte_in >= u8v_pkg::CONT_MIN && byte_in <= u8v_pkg::CONT_F4_MAX;
  end

endmodule

// ===== hw/rtl/u8v_merge.sv =====
// Merge stage: folds the lane findings in byte order into the sequence state.
// Depends on u8v_pkg; holds the cross-item state registers.
module u8v_merge (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                accept,
  input  logic [3:0]                                          byte_count,
  input  logic                                                end_of_string,
  input  u8v_pkg::lane_info_t [u8v_pkg::BYTES_PER_ITEM-1:0]   lanes,
  output u8v_pkg::verdict_t                                   verdict
);

  logic [1:0]           owed;
  u8v_pkg::cont_class_t first_cls;
  logic                 error_seen;
  logic [1:0]           owed_next;
  u8v_pkg::cont_class_t first_cls_next;
  logic                 error_seen_next;
  logic [3:0]           count_eff;

  // Clip the byte count to the lane count
  assign count_eff = (byte_count > 4'(u8v_pkg::BYTES_PER_ITEM)) ?
                     4'(u8v_pkg::BYTES_PER_ITEM) : byte_count;

  // Walk the active lanes in order
  always_comb begin
    logic                 cont_ok;
    logic                 take_lead;
    u8v_pkg::lane_info_t  li;
    owed_next       = owed;
    first_cls_next  = first_cls;
    error_seen_next = error_seen;
    for (int i = 0; i < u8v_pkg::BYTES_PER_ITEM; i++) begin
      li = lanes[i];
      case (first_cls_next)
        u8v_pkg::CLS_E0: cont_ok = li.in_e0;
        u8v_pkg::CLS_ED: cont_ok = li.in_ed;
        u8v_pkg::CLS_F0: cont_ok = li.in_f0;
        u8v_pkg::CLS_F4: cont_ok = li.in_f4;
        default:         cont_ok = li.in_normal;
      endcase
      take_lead = 1'b0;
      if (4'(i) < count_eff) begin
        if (owed_next == 2'd0) begin
          take_lead = 1'b1;
        end else if (cont_ok) begin
          owed_next      = owed_next - 2'd1;
          first_cls_next = u8v_pkg::CLS_NORMAL;
        end else begin
          // Bad continuation: flag it and retry the byte as a lead
          error_seen_next = 1'b1;
          take_lead       = 1'b1;
        end
        if (take_lead) begin
          if (li.lead_ok) begin
            owed_next      = li.lead_owed;
            first_cls_next = li.lead_cls;
          end else begin
            error_seen_next = 1'b1;
            owed_next       = 2'd0;
            first_cls_next  = u8v_pkg::CLS_NORMAL;
          end
        end
      end
    end
  end

  // Emit the verdict on the last item of a string
  assign verdict.valid = accept && end_of_string;
  assign verdict.ok    = !error_seen_next && (owed_next == 2'd0);

  // Advance the state; clear it at the end of a string
  always_ff @(posedge clk) begin
    if (rst) begin
      owed       <= 2'd0;
      first_cls  <= u8v_pkg::CLS_NORMAL;
      error_seen <= 1'b0;
    end else if (accept) begin
      if (end_of_string) begin
        owed       <= 2'd0;
        first_cls  <= u8v_pkg::CLS_NORMAL;
        error_seen <= 1'b0;
      end else begin
        owed       <= owed_next;
        first_cls  <= first_cls_next;
        error_seen <= error_seen_next;
      end
    end
  end

endmodule

// ===== hw/rtl/utf8_stream_validator_unit.sv =====
// Top level of the UTF-8 stream validator: byte lanes, merge stage, output buffer.
// Depends on u8v_pkg, u8v_lane, u8v_merge and the assertion macro header.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+----------------------------------------
//  item    | in        | item_valid / item_stall     | data_bytes, byte_count, end_of_string
//  result  | out       | result_valid / result_stall | string_valid
//
// One item is taken every cycle while item_stall is low; all eight byte lanes decode in parallel
// and the merge stage folds them into the sequence state in the same cycle, so the state loop
// sets the rate at one item per cycle. The end-of-string verdict is registered into the output
// register, or into the skid entry when the output stalls. A two-entry output buffer lets items
// flow while a verdict waits; item_stall rises only when both entries are held. Reset
// (synchronous) clears the sequence state and empties the buffer.
`include "utf8_stream_validator_unit_macros.svh"

module utf8_stream_validator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [63:0] data_bytes,
  input  logic [3:0]  byte_count,
  input  logic        end_of_string,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        string_valid
);

  u8v_pkg::lane_info_t [u8v_pkg::BYTES_PER_ITEM-1:0] lanes;
  u8v_pkg::verdict_t verdict;
  logic accept;
  logic skid_valid;
  logic skid_ok;
  logic result_valid_next;
  logic skid_valid_next;
  logic string_valid_next;
  logic skid_ok_next;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;

  // Decode each byte in its own lane
  for (genvar g = 0; g < u8v_pkg::BYTES_PER_ITEM; g++) begin : g_lane
    u8v_lane u_lane (
      .byte_in (data_bytes[8*g +: 8]),
      .info    (lanes[g])
    );
  end

  // Fold lane results into the string state
  u8v_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .byte_count    (byte_count),
    .end_of_string (end_of_string),
    .lanes         (lanes),
    .verdict       (verdict)
  );

  // Output register plus skid entry
  always_comb begin
    result_valid_next = result_valid;
    skid_valid_next   = skid_valid;
    string_valid_next = string_valid;
    skid_ok_next      = skid_ok;
    if (result_valid && !result_stall) begin
      if (skid_valid) begin
        string_valid_next = skid_ok;
        skid_valid_next   = 1'b0;
      end else if (verdict.valid) begin
        string_valid_next = verdict.ok;
      end else begin
        result_valid_next = 1'b0;
      end
    end else if (result_valid) begin
      if (verdict.valid) begin
        skid_valid_next = 1'b1;
        skid_ok_next    = verdict.ok;
      end
    end else if (verdict.valid) begin
      result_valid_next = 1'b1;
      string_valid_next = verdict.ok;
    end
  end

  // Hold control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
      skid_valid   <= skid_valid_next;
    end
  end

  // Hold verdict payload
  always_ff @(posedge clk) begin
    string_valid <= string_valid_next;
    skid_ok      <= skid_ok_next;
  end

  `U8V_ASSERT_IMP(a_skid_needs_out, clk, rst, skid_valid, result_valid)
  `U8V_ASSERT_NXT(a_end_gives_result, clk, rst, accept && end_of_string, result_valid)
  `U8V_ASSERT_NXT(a_skid_drains, clk, rst, skid_valid && !result_stall, result_valid && !skid_valid)

endmodule
